// ===== rtl/core/bpskcl_pkg.sv =====
// Shared constants, datapath command codes and quarter-wave sine/cosine tables.
`default_nettype none

package bpskcl_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;

  localparam int PHASE_W   = 32;
  localparam int FREQ_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int CFG_IDX_W = 1;
  localparam int COEF_W    = 16;
  localparam int QTAB_BITS = TABLE_ADDR_BITS - 2;
  localparam int QTAB_SIZE = 1 << QTAB_BITS;
  localparam int QTAB_W    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN  = 1'b1;

  localparam logic [GAIN_W-1:0] PHASE_GAIN_RESET = 24'd352460;
  localparam logic [GAIN_W-1:0] FREQ_GAIN_RESET  = 24'd24886;

  // Only the top PHASE_BITS bits of the phase accumulator are kept.
  localparam logic [PHASE_W-1:0] PHASE_KEEP = {PHASE_W{1'b1}} << (PHASE_W - PHASE_BITS);

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROT_I1,
    OP_ROT_I2,
    OP_ROT_Q1,
    OP_ROT_Q2,
    OP_ROUND_Q,
    OP_ERR,
    OP_FGAIN,
    OP_PGAIN,
    OP_UPDATE
  } dp_op_t;

  typedef logic [QTAB_W-1:0] qtab_t [QTAB_SIZE];

  // One Taylor term divisor, by the term number and by sine or cosine.
  function automatic logic [63:0] term_div(logic [63:0] v, int k, logic odd);
    logic [63:0] q;
    q = v;
    case (k)
      1:       q = odd ? v / 64'd6   : v / 64'd2;
      2:       q = odd ? v / 64'd20  : v / 64'd12;
      3:       q = odd ? v / 64'd42  : v / 64'd30;
      4:       q = odd ? v / 64'd72  : v / 64'd56;
      5:       q = odd ? v / 64'd110 : v / 64'd90;
      6:       q = odd ? v / 64'd156 : v / 64'd132;
      7:       q = odd ? v / 64'd210 : v / 64'd182;
      default: q = v;
    endcase
    return q;
  endfunction

  // Sine (odd set) or cosine of x in Q2.30, result scaled to 32767.
  function automatic logic [QTAB_W-1:0] taylor_q15(logic [63:0] x, logic odd);
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic signed [63:0] scaled;
    x2  = (x * x) >> 30;
    mag = odd ? x : ONE_Q30;
    sum = signed'(mag);
    for (int k = 1; k <= 7; k++) begin
      mag = term_div((mag * x2) >> 30, k, odd);
      if ((k % 2) == 1) begin
        sum = sum - signed'(mag);
      end else begin
        sum = sum + signed'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    scaled = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    return scaled[QTAB_W-1:0];
  endfunction

  function automatic qtab_t build_qtab(logic odd);
    qtab_t       t;
    logic [63:0] x;
    for (int r = 0; r < QTAB_SIZE; r++) begin
      x    = (64'(r) * HALFPI_Q30) >> QTAB_BITS;
      t[r] = taylor_q15(x, odd);
    end
    return t;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab(1'b1);
  localparam qtab_t COS_QTAB = build_qtab(1'b0);

endpackage

`default_nettype wire

// ===== rtl/core/bpskcl_dp.sv =====
// Costas loop datapath: derotation, phase detector, loop filter and accumulators.
`default_nettype none

module bpskcl_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  bpskcl_pkg::dp_op_t                       op,
  input  logic                                     cfg_we,
  input  logic [bpskcl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpskcl_pkg::GAIN_W-1:0]            cfg_data,
  input  logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] in_i,
  input  logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] in_q,
  output logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] out_q,
  output logic signed [bpskcl_pkg::FREQ_W-1:0]      freq_estimate
);

  localparam int SB      = bpskcl_pkg::SAMPLE_BITS;
  localparam int ACC_W   = SB + 17;
  localparam int SH_W    = ACC_W - 14;
  localparam int MUL_A_W = bpskcl_pkg::GAIN_W + 1;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // The error reaches +2^30 when both rotated outputs sit at the negative rail.
  localparam int ERR_W   = 32;
  localparam int ERR_SHR = (2 * SB >= 32) ? 2 * SB - 32 : 0;
  localparam int ERR_SHL = (2 * SB < 32) ? 32 - 2 * SB : 0;
  localparam int GSHIFT  = 22;
  localparam int INC_W   = 33;
  localparam int FSUM_W  = bpskcl_pkg::FREQ_W + 2;
  localparam int S_MAX   = 2 ** (SB - 1) - 1;
  localparam int S_MIN   = -(2 ** (SB - 1));

  localparam logic signed [FSUM_W-1:0] F_MAX = FSUM_W'(64'sd2147483647);
  localparam logic signed [FSUM_W-1:0] F_MIN = FSUM_W'(-64'sd2147483648);

  logic signed [SB-1:0]                      si, sq, oi, oq;
  logic signed [bpskcl_pkg::COEF_W-1:0]      cos_c, sin_c;
  logic signed [ACC_W-1:0]                   acc;
  logic signed [ERR_W-1:0]                   err;
  logic signed [INC_W-1:0]                   finc, pinc;
  logic signed [bpskcl_pkg::FREQ_W-1:0]      freq_acc;
  logic [bpskcl_pkg::PHASE_W-1:0]            phase_acc;
  logic [bpskcl_pkg::GAIN_W-1:0]             phase_gain, freq_gain;

  logic [1:0]                                quad;
  logic [bpskcl_pkg::QTAB_BITS-1:0]          qaddr;
  logic signed [bpskcl_pkg::COEF_W-1:0]      s_mag, c_mag, sin_next, cos_next;
  logic signed [MUL_A_W-1:0]                 mul_a;
  logic signed [MUL_B_W-1:0]                 mul_b;
  logic signed [PROD_W-1:0]                  prod, prod_shr;
  logic signed [2*SB-1:0]                    prod_pair;
  logic signed [63:0]                        err_wide;
  logic signed [FSUM_W-1:0]                  fsum;
  logic signed [bpskcl_pkg::FREQ_W-1:0]      freq_next;
  logic [bpskcl_pkg::PHASE_W-1:0]            phase_next;

  // Round half up by 15 bits and saturate to the sample width.
  function automatic logic signed [SB-1:0] round_sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0]  t;
    logic signed [SH_W-1:0] sh;
    logic signed [SB-1:0]   r;
    t  = (ACC_W + 1)'(v) + (ACC_W + 1)'(32'sd16384);
    sh = t[ACC_W:15];
    if (sh > SH_W'(S_MAX)) begin
      r = SB'(S_MAX);
    end else if (sh < SH_W'(S_MIN)) begin
      r = SB'(S_MIN);
    end else begin
      r = sh[SB-1:0];
    end
    return r;
  endfunction

  // Quarter-wave table lookup with quadrant folding.
  assign quad  = phase_acc[bpskcl_pkg::PHASE_W-1 -: 2];
  assign qaddr = phase_acc[bpskcl_pkg::PHASE_W-3 -: bpskcl_pkg::QTAB_BITS];
  assign s_mag = signed'({1'b0, bpskcl_pkg::SIN_QTAB[qaddr]});
  assign c_mag = signed'({1'b0, bpskcl_pkg::COS_QTAB[qaddr]});

  always_comb begin
    case (quad)
      2'd0:    begin sin_next = s_mag;  cos_next = c_mag;  end
      2'd1:    begin sin_next = c_mag;  cos_next = -s_mag; end
      2'd2:    begin sin_next = -s_mag; cos_next = -c_mag; end
      default: begin sin_next = -c_mag; cos_next = s_mag;  end
    endcase
  end

  // The single shared multiplier and its operand selection.
  always_comb begin
    case (op) inside
      bpskcl_pkg::OP_ROT_I1, bpskcl_pkg::OP_ROT_Q2: mul_a = MUL_A_W'(si);
      bpskcl_pkg::OP_ROT_I2, bpskcl_pkg::OP_ROT_Q1: mul_a = MUL_A_W'(sq);
      bpskcl_pkg::OP_ERR:                           mul_a = MUL_A_W'(oi);
      bpskcl_pkg::OP_FGAIN:                         mul_a = signed'({1'b0, freq_gain});
      bpskcl_pkg::OP_PGAIN:                         mul_a = signed'({1'b0, phase_gain});
      default:                                      mul_a = '0;
    endcase
    case (op) inside
      bpskcl_pkg::OP_ROT_I1, bpskcl_pkg::OP_ROT_Q1: mul_b = MUL_B_W'(cos_c);
      bpskcl_pkg::OP_ROT_I2, bpskcl_pkg::OP_ROT_Q2: mul_b = MUL_B_W'(sin_c);
      bpskcl_pkg::OP_ERR:                           mul_b = MUL_B_W'(oq);
      bpskcl_pkg::OP_FGAIN, bpskcl_pkg::OP_PGAIN:   mul_b = MUL_B_W'(err);
      default:                                      mul_b = '0;
    endcase
  end

  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_shr  = prod >>> GSHIFT;
  assign prod_pair = prod[2*SB-1:0];
  assign err_wide  = (64'(prod_pair) >>> ERR_SHR) <<< ERR_SHL;

  // Loop filter: saturating frequency integrator, wrapping phase integrator.
  assign fsum = FSUM_W'(freq_acc) + FSUM_W'(finc);
  always_comb begin
    if (fsum > F_MAX) begin
      freq_next = F_MAX[bpskcl_pkg::FREQ_W-1:0];
    end else if (fsum < F_MIN) begin
      freq_next = F_MIN[bpskcl_pkg::FREQ_W-1:0];
    end else begin
      freq_next = fsum[bpskcl_pkg::FREQ_W-1:0];
    end
  end

  assign phase_next = (phase_acc + unsigned'(freq_acc) + unsigned'(pinc[31:0]))
                      & bpskcl_pkg::PHASE_KEEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      freq_acc   <= '0;
      phase_gain <= bpskcl_pkg::PHASE_GAIN_RESET;
      freq_gain  <= bpskcl_pkg::FREQ_GAIN_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bpskcl_pkg::REG_PHASE_GAIN) begin
          phase_gain <= cfg_data;
        end else if (cfg_index == bpskcl_pkg::REG_FREQ_GAIN) begin
          freq_gain <= cfg_data;
        end
      end
      if (op == bpskcl_pkg::OP_PGAIN) begin
        freq_acc <= freq_next;
      end
      if (op == bpskcl_pkg::OP_UPDATE) begin
        phase_acc <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      bpskcl_pkg::OP_LOAD: begin
        si    <= in_i;
        sq    <= in_q;
        cos_c <= cos_next;
        sin_c <= sin_next;
      end
      bpskcl_pkg::OP_ROT_I1: acc <= prod[ACC_W-1:0];
      bpskcl_pkg::OP_ROT_I2: acc <= acc + prod[ACC_W-1:0];
      bpskcl_pkg::OP_ROT_Q1: begin
        oi  <= round_sat(acc);
        acc <= prod[ACC_W-1:0];
      end
      bpskcl_pkg::OP_ROT_Q2:  acc <= acc - prod[ACC_W-1:0];
      bpskcl_pkg::OP_ROUND_Q: oq <= round_sat(acc);
      bpskcl_pkg::OP_ERR:     err <= err_wide[ERR_W-1:0];
      bpskcl_pkg::OP_FGAIN:   finc <= prod_shr[INC_W-1:0];
      bpskcl_pkg::OP_PGAIN:   pinc <= prod_shr[INC_W-1:0];
      bpskcl_pkg::OP_UPDATE: begin
        out_i         <= oi;
        out_q         <= oq;
        freq_estimate <= freq_acc;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpskcl_ctrl.sv =====
// Costas loop sequencer: steps the datapath through one sample and owns the handshakes.
`default_nettype none

module bpskcl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output bpskcl_pkg::dp_op_t op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_I1,
    ST_ROT_I2,
    ST_ROT_Q1,
    ST_ROT_Q2,
    ST_ROUND_Q,
    ST_ERR,
    ST_FGAIN,
    ST_PGAIN,
    ST_UPDATE
  } state_t;

  state_t state;
  logic   out_blocked;

  assign in_stall    = (state != ST_IDLE);
  assign out_blocked = out_valid && out_stall;

  always_comb begin
    unique case (state)
      ST_IDLE:    op = in_valid ? bpskcl_pkg::OP_LOAD : bpskcl_pkg::OP_NONE;
      ST_ROT_I1:  op = bpskcl_pkg::OP_ROT_I1;
      ST_ROT_I2:  op = bpskcl_pkg::OP_ROT_I2;
      ST_ROT_Q1:  op = bpskcl_pkg::OP_ROT_Q1;
      ST_ROT_Q2:  op = bpskcl_pkg::OP_ROT_Q2;
      ST_ROUND_Q: op = bpskcl_pkg::OP_ROUND_Q;
      ST_ERR:     op = bpskcl_pkg::OP_ERR;
      ST_FGAIN:   op = bpskcl_pkg::OP_FGAIN;
      ST_PGAIN:   op = bpskcl_pkg::OP_PGAIN;
      ST_UPDATE:  op = out_blocked ? bpskcl_pkg::OP_NONE : bpskcl_pkg::OP_UPDATE;
      default:    op = bpskcl_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (op == bpskcl_pkg::OP_UPDATE) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ROT_I1;
          end
        end
        ST_ROT_I1:  state <= ST_ROT_I2;
        ST_ROT_I2:  state <= ST_ROT_Q1;
        ST_ROT_Q1:  state <= ST_ROT_Q2;
        ST_ROT_Q2:  state <= ST_ROUND_Q;
        ST_ROUND_Q: state <= ST_ERR;
        ST_ERR:     state <= ST_FGAIN;
        ST_FGAIN:   state <= ST_PGAIN;
        ST_PGAIN:   state <= ST_UPDATE;
        ST_UPDATE: begin
          if (!out_blocked) begin
            state <= ST_IDLE;
          end
        end
        default:    state <= ST_IDLE;
      endcase
    end
  end

  a_rise_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("result word appeared without an update step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == bpskcl_pkg::OP_UPDATE) |-> !(out_valid && out_stall))
    else $error("update would overwrite a pending result word");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (op == bpskcl_pkg::OP_LOAD) |-> (in_valid && !in_stall))
    else $error("sample load without an accepted word");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_ROT_I1))
    else $error("accepted word did not start the rotation");

endmodule

`default_nettype wire

// ===== rtl/core/bpsk_costas_loop_unit.sv =====
// Top level of the second-order BPSK Costas loop: sequencer plus datapath.
// Each accepted word passes through the accept step, seven multiply steps on
// one shared multiplier, a rounding step and the loop update. The result word
// is registered at the update step; a new word is taken only after the update,
// which is delayed only while the previous result is still stalled.
// Synchronous active-high rst clears phase and frequency, restores the default
// gains and empties the output register.
`default_nettype none

module bpsk_costas_loop_unit (
  input  logic                                      clk,
  input  logic                                      rst,
  // Input sample channel.
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] in_i,
  input  logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] in_q,
  // Result channel.
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] out_q,
  output logic signed [bpskcl_pkg::FREQ_W-1:0]      freq_estimate,
  // Gain register write port.
  input  logic                                      cfg_we,
  input  logic [bpskcl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bpskcl_pkg::GAIN_W-1:0]             cfg_data
);

  // Command from the sequencer to the datapath; one step per cycle while the update is not held by a stalled result.
  bpskcl_pkg::dp_op_t op;

  // The sequencer accepts a word only when idle. The output register lets the
  // next word enter while the previous result still waits to be taken; the
  // loop update step is held back only while that result is stalled.
  bpskcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op)
  );

  // The datapath derotates the sample by the table phase, forms the I*Q error,
  // scales it by both gains and advances the frequency and phase integrators.
  bpskcl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_i          (in_i),
    .in_q          (in_q),
    .out_i         (out_i),
    .out_q         (out_q),
    .freq_estimate (freq_estimate)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for bpsk_costas_loop_unit with a bit-exact loop predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sine/cosine table geometry, rebuilt here from the series definition.
  localparam int LUT_BITS  = bpskcl_pkg::TABLE_ADDR_BITS;
  localparam int LUT_SIZE  = 1 << LUT_BITS;
  localparam int QUAD_BITS = LUT_BITS - 2;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned UNITY_Q30        = 64'd1 << 30;

  localparam longint SAMPLE_MAX = (longint'(1) << (bpskcl_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint FREQ_MAX   = (longint'(1) << (bpskcl_pkg::FREQ_W - 1)) - 1;
  localparam longint FREQ_MIN   = -FREQ_MAX - 1;
  localparam logic [bpskcl_pkg::PHASE_W-1:0] PHASE_MASK =
    {bpskcl_pkg::PHASE_W{1'b1}} << (bpskcl_pkg::PHASE_W - bpskcl_pkg::PHASE_BITS);

  localparam logic [bpskcl_pkg::GAIN_W-1:0] GAIN_MAX = {bpskcl_pkg::GAIN_W{1'b1}};

  // Run control: the length of the long result hold, the settle and drain
  // margins and the watchdog limit.
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef logic signed [bpskcl_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [bpskcl_pkg::FREQ_W-1:0]      freq_t;
  typedef logic [bpskcl_pkg::GAIN_W-1:0]             gain_t;
  typedef struct packed {
    sample_t i;
    sample_t q;
  } iq_word_t;
  typedef struct packed {
    sample_t i;
    sample_t q;
    freq_t   freq;
  } derot_word_t;

  // DUT ports. Every input starts at a known value.
  logic                                clk;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  sample_t                             in_i      = '0;
  sample_t                             in_q      = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  sample_t                             out_i;
  sample_t                             out_q;
  freq_t                               freq_estimate;
  logic                                cfg_we    = 1'b0;
  logic [bpskcl_pkg::CFG_IDX_W-1:0]    cfg_index = bpskcl_pkg::REG_PHASE_GAIN;
  gain_t                               cfg_data  = '0;

  bpsk_costas_loop_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_i          (in_i),
    .in_q          (in_q),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_i         (out_i),
    .out_q         (out_q),
    .freq_estimate (freq_estimate),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor copy of the loop state and of the two gain registers.
  logic [bpskcl_pkg::PHASE_W-1:0] loop_phase;
  freq_t                          loop_freq;
  gain_t                          kp_gain;
  gain_t                          ki_gain;
  int                             cos_lut [LUT_SIZE];
  int                             sin_lut [LUT_SIZE];

  // Sample words waiting to be sent, and derotated words waiting to come back.
  iq_word_t    pending_samples [$];
  derot_word_t derot_expected [$];

  // Handshake bookkeeping shared between the clocked processes.
  logic in_took = 1'b0;
  int   burst_odds = 0;
  int   in_gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  // Run statistics.
  int   error_count = 0;
  int   words_taken = 0;
  int   results_seen = 0;
  int   gain_settings = 0;
  int   freq_rail_hits = 0;
  int   clip_count = 0;
  bit   lut_seen [LUT_SIZE];

  int   corners [5] = '{-32768, -1, 0, 1, 32767};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Truncated Taylor series of sin or cos on [0, pi/2] in Q2.30, scaled to
  // 32767 with the rounding the table uses.
  function automatic int trig_series_q15(longint unsigned x, bit want_sin);
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned dv;
    longint          sum;
    x2  = (x * x) >> 30;
    mag = want_sin ? x : UNITY_Q30;
    sum = longint'(mag);
    for (int k = 1; k <= 7; k++) begin
      dv  = 64'(want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k));
      mag = ((mag * x2) >> 30) / dv;
      if (k % 2 == 1) begin
        sum -= longint'(mag);
      end else begin
        sum += longint'(mag);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(UNITY_Q30)) sum = longint'(UNITY_Q30);
    return int'((sum * 32767 + (longint'(1) << 29)) >>> 30);
  endfunction

  // Full-turn tables built by folding the first quadrant.
  function automatic void fill_trig_luts();
    longint unsigned x;
    int              s;
    int              c;
    for (int n = 0; n < LUT_SIZE; n++) begin
      x = (longint'(n % (1 << QUAD_BITS)) * QUARTER_TURN_Q30) >> QUAD_BITS;
      s = trig_series_q15(x, 1'b1);
      c = trig_series_q15(x, 1'b0);
      case (n >> QUAD_BITS)
        0: begin
          sin_lut[n] = s;
          cos_lut[n] = c;
        end
        1: begin
          sin_lut[n] = c;
          cos_lut[n] = -s;
        end
        2: begin
          sin_lut[n] = -s;
          cos_lut[n] = -c;
        end
        default: begin
          sin_lut[n] = -c;
          cos_lut[n] = s;
        end
      endcase
    end
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One loop iteration: derotate by the current phase, form the I*Q error,
  // update the saturating frequency and the wrapping phase.
  function automatic derot_word_t step_loop(iq_word_t w);
    longint      c;
    longint      s;
    longint      raw_i;
    longint      raw_q;
    longint      oi;
    longint      oq;
    longint      err;
    longint      finc;
    longint      pinc;
    longint      fsum;
    int unsigned addr;
    derot_word_t r;
    addr = loop_phase >> (bpskcl_pkg::PHASE_W - LUT_BITS);
    lut_seen[addr] = 1'b1;
    c = longint'(cos_lut[addr]);
    s = longint'(sin_lut[addr]);
    raw_i = (longint'(w.i) * c + longint'(w.q) * s + 16384) >>> 15;
    raw_q = (longint'(w.q) * c - longint'(w.i) * s + 16384) >>> 15;
    oi = clip(raw_i, SAMPLE_MIN, SAMPLE_MAX);
    oq = clip(raw_q, SAMPLE_MIN, SAMPLE_MAX);
    if (oi != raw_i || oq != raw_q) clip_count++;
    // With 16-bit samples the product already has 30 fraction bits.
    err  = oi * oq;
    finc = (longint'(ki_gain) * err) >>> 22;
    pinc = (longint'(kp_gain) * err) >>> 22;
    fsum = clip(longint'(loop_freq) + finc, FREQ_MIN, FREQ_MAX);
    if (fsum == FREQ_MIN || fsum == FREQ_MAX) freq_rail_hits++;
    loop_freq  = fsum[bpskcl_pkg::FREQ_W-1:0];
    loop_phase = (loop_phase + fsum[bpskcl_pkg::PHASE_W-1:0]
                  + pinc[bpskcl_pkg::PHASE_W-1:0]) & PHASE_MASK;
    r.i    = oi[bpskcl_pkg::SAMPLE_BITS-1:0];
    r.q    = oq[bpskcl_pkg::SAMPLE_BITS-1:0];
    r.freq = fsum[bpskcl_pkg::FREQ_W-1:0];
    return r;
  endfunction

  // Everything the testbench observes is sampled here, at the rising edge.
  // The result check runs before the new prediction is queued so that a
  // result can never be matched against the word accepted in the same edge.
  always @(posedge clk) begin : loop_monitor
    derot_word_t want;
    iq_word_t    seen_in;
    if (rst) begin
      loop_phase = '0;
      loop_freq  = '0;
      kp_gain    = bpskcl_pkg::PHASE_GAIN_RESET;
      ki_gain    = bpskcl_pkg::FREQ_GAIN_RESET;
      in_took   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (derot_expected.size() == 0) begin
          $error("result word with nothing expected: out_i %0d out_q %0d freq_estimate %0d",
                 out_i, out_q, freq_estimate);
          error_count++;
        end else begin
          want = derot_expected.pop_front();
          if (want.i !== out_i) begin
            $error("out_i: expected %0d, actual %0d", want.i, out_i);
            error_count++;
          end
          if (want.q !== out_q) begin
            $error("out_q: expected %0d, actual %0d", want.q, out_q);
            error_count++;
          end
          if (want.freq !== freq_estimate) begin
            $error("freq_estimate: expected %0d, actual %0d", want.freq, freq_estimate);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          bpskcl_pkg::REG_PHASE_GAIN: kp_gain = cfg_data;
          bpskcl_pkg::REG_FREQ_GAIN:  ki_gain = cfg_data;
          default:                    ;
        endcase
      end
      if (in_valid && !in_stall) begin
        seen_in.i = in_i;
        seen_in.q = in_q;
        derot_expected.push_back(step_loop(seen_in));
        words_taken++;
      end
      in_took <= in_valid && !in_stall;
    end
  end

  // Sample driver. A new word is presented only once the previous one has
  // been taken (or nothing was offered), so valid never reacts to in_stall
  // and a stalled word holds still. Idle gaps come in random-length bursts.
  always @(negedge clk) begin : sample_driver
    iq_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        in_valid <= 1'b0;
      end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
        in_gap_left = $urandom_range(0, 17);
        in_valid   <= 1'b0;
      end else begin
        w = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_i     <= w.i;
        in_q     <= w.q;
      end
    end
  end

  // Result back-pressure. Besides short random bursts, the receiver once
  // refuses results for a long stretch while the sender still has plenty of
  // words queued, so the block backs up and stalls its input.
  always @(negedge clk) begin : result_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 300 && pending_samples.size() > 40) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any word moving on either channel means
  // the block has hung.
  always @(posedge clk) begin : hang_watchdog
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_sample(int a, int b);
    iq_word_t w;
    w.i = sample_t'(clip(a, SAMPLE_MIN, SAMPLE_MAX));
    w.q = sample_t'(clip(b, SAMPLE_MIN, SAMPLE_MAX));
    pending_samples.push_back(w);
  endtask

  // Waits until every queued word has been sent and answered, then lets the
  // block settle before any register write.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || derot_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both gains, in random order, while the block is idle.
  task automatic write_gains(gain_t kp, gain_t ki);
    bit freq_first;
    freq_first = ($urandom_range(0, 1) == 1);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= freq_first ? bpskcl_pkg::REG_FREQ_GAIN : bpskcl_pkg::REG_PHASE_GAIN;
    cfg_data  <= freq_first ? ki : kp;
    @(negedge clk);
    cfg_index <= freq_first ? bpskcl_pkg::REG_PHASE_GAIN : bpskcl_pkg::REG_FREQ_GAIN;
    cfg_data  <= freq_first ? kp : ki;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gain_settings++;
  endtask

  // One gain setting: mostly BPSK bursts with a carrier offset, amplitude
  // and noise of their own, which is what the loop is built to track, mixed
  // with fully random words and full-scale corner words.
  task automatic run_phase(gain_t kp, gain_t ki, int count, int odds);
    int          kind;
    int          len;
    int          amp;
    int          noise;
    int          sym;
    int          nz_i;
    int          nz_q;
    int unsigned idx;
    logic [31:0] theta;
    logic [31:0] dtheta;
    burst_odds = odds;
    write_gains(kp, ki);
    while (pending_samples.size() < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len    = $urandom_range(8, 40);
        amp    = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(500, 32767);
        noise  = $urandom_range(0, 1500);
        theta  = $urandom;
        dtheta = $urandom_range(0, 1 << 25);
        if ($urandom_range(0, 1) == 1) dtheta = -dtheta;
        for (int n = 0; n < len; n++) begin
          sym  = ($urandom_range(0, 1) == 1) ? 1 : -1;
          idx  = theta >> (32 - LUT_BITS);
          nz_i = $urandom_range(0, 2 * noise);
          nz_q = $urandom_range(0, 2 * noise);
          queue_sample(((sym * amp * cos_lut[idx]) >>> 15) + nz_i - noise,
                       ((sym * amp * sin_lut[idx]) >>> 15) + nz_q - noise);
          theta += dtheta;
        end
      end else if (kind < 9) begin
        len = $urandom_range(1, 8);
        for (int n = 0; n < len; n++) begin
          pending_samples.push_back(iq_word_t'($urandom));
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int n = 0; n < len; n++) begin
          queue_sample(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]);
        end
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int visited;
    fill_trig_luts();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset gains: full-scale corners, zero, the
    // smallest nonzero values and single-axis inputs.
    burst_odds = 6;
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(0, 0);
    queue_sample(-32768, 0);
    queue_sample(0, -32768);
    queue_sample(32767, 0);
    queue_sample(0, 32767);
    queue_sample(1, 1);
    queue_sample(-1, -1);
    queue_sample(-1, 1);
    queue_sample(1, -1);
    queue_sample(-32768, -1);
    wait_drained();

    // Both gains at full scale: a few corner words drive the frequency
    // accumulator into its rails and sweep the phase across the table.
    write_gains(GAIN_MAX, GAIN_MAX);
    for (int n = 0; n < 4; n++) queue_sample(32767, 32767);
    for (int n = 0; n < 4; n++) queue_sample(32767, -32768);
    queue_sample(-32768, -32768);
    queue_sample(-32768, 32767);
    wait_drained();

    // Gain settings from frozen loop to full scale, then random and
    // realistic values, ending on the defaults with no idling at all.
    run_phase('0, '0, 120, 8);
    run_phase(GAIN_MAX, GAIN_MAX, 150, 6);
    run_phase(GAIN_MAX, '0, 150, 10);
    run_phase('0, GAIN_MAX, 120, 0);
    run_phase(gain_t'($urandom), gain_t'($urandom), 150, 8);
    run_phase(gain_t'($urandom_range(0, 1 << 20)), gain_t'($urandom_range(0, 1 << 16)),
              150, 4);
    run_phase(gain_t'($urandom_range(100000, 600000)), gain_t'($urandom_range(1000, 60000)),
              200, 12);
    run_phase(bpskcl_pkg::PHASE_GAIN_RESET, bpskcl_pkg::FREQ_GAIN_RESET, 200, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (derot_expected.size() != 0) begin
      $error("%0d expected result words never arrived", derot_expected.size());
      error_count++;
    end

    visited = 0;
    foreach (lut_seen[n]) visited += int'(lut_seen[n]);
    $display("Sent %0d sample words under %0d gain settings and checked %0d results.",
             words_taken, gain_settings + 1, results_seen);
    $display("Frequency at a rail %0d times, rotation clipped %0d times, %0d of %0d angles.",
             freq_rail_hits, clip_count, visited, LUT_SIZE);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
